[hdl/ehq_pkg.sv]
// ----------------------------------------------------------------------------
// ehq_pkg
// Shared types and constants for the eight-channel hold-time input qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ehq_pkg;

   localparam int CHANNELS    = 8;
   localparam int COUNT_BITS  = 16;
   localparam int HOLD_BITS   = 16;
   localparam int FIELD_BITS  = 2;
   localparam int WORD_BITS   = CHANNELS * FIELD_BITS;
   localparam int KIND_BITS   = 2;
   localparam int CSR_IDX_BITS = 1;
   localparam int CSR_DATA_BITS = 16;
   localparam int CMP_BITS    = (COUNT_BITS > HOLD_BITS) ? COUNT_BITS : HOLD_BITS;

   typedef logic [FIELD_BITS-1:0] status_type;
   typedef logic [KIND_BITS-1:0]  kind_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [HOLD_BITS-1:0]  hold_type;

   // item kinds; the unused code behaves as a query
   localparam kind_type KIND_EDGE  = 2'd0;
   localparam kind_type KIND_TICK  = 2'd1;
   localparam kind_type KIND_QUERY = 2'd2;

   // status field codes
   localparam status_type ST_NONE = 2'b00;
   localparam status_type ST_HIGH = 2'b01;
   localparam status_type ST_LOW  = 2'b10;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] REG_HOLD_TICKS     = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_QUALIFIED_MASK = 1'd1;

   localparam hold_type HOLD_RESET = 16'd10;
   localparam hold_type HOLD_MIN   = 16'd1;

   // control for one channel's state update
   typedef struct packed {
      logic     update;
      kind_type kind;
      hold_type hold;
   } chan_ctl_type;

endpackage

`default_nettype wire

[hdl/ehq_chan.sv]
// ----------------------------------------------------------------------------
// ehq_chan
// One channel: arm flag, high/low hold counters and qualified status.
// ----------------------------------------------------------------------------
`default_nettype none

module ehq_chan (
   input  wire                    clock,
   input  wire                    reset,
   input  ehq_pkg::chan_ctl_type  ctl,
   input  wire                    edge_bit,
   input  wire                    level,
   output ehq_pkg::status_type    status_next
);
   import ehq_pkg::*;

   logic       armed_ff, armed_in;
   status_type status_ff, status_in;
   count_type  high_ff, high_in;
   count_type  low_ff, low_in;
   count_type  high_inc, low_inc;
   logic       high_hit, low_hit;

   assign high_inc = high_ff + count_type'(1);
   assign low_inc  = low_ff + count_type'(1);
   assign high_hit = CMP_BITS'(high_inc) >= CMP_BITS'(ctl.hold);
   assign low_hit  = CMP_BITS'(low_inc) >= CMP_BITS'(ctl.hold);

   always_comb begin
      armed_in  = armed_ff;
      status_in = status_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      if (ctl.update) begin
         if (ctl.kind == KIND_EDGE) begin
            if (edge_bit) begin
               armed_in = 1'b1;
               high_in  = '0;
               low_in   = '0;
            end
         end else if (ctl.kind == KIND_TICK && armed_ff) begin
            if (level) begin
               if (high_hit) begin
                  status_in = ST_HIGH;
                  high_in   = '0;
               end else begin
                  high_in = high_inc;
               end
            end else begin
               if (low_hit) begin
                  status_in = ST_LOW;
                  low_in    = '0;
               end else begin
                  low_in = low_inc;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff  <= 1'b0;
         status_ff <= ST_HIGH;
         high_ff   <= '0;
         low_ff    <= '0;
      end else begin
         armed_ff  <= armed_in;
         status_ff <= status_in;
         high_ff   <= high_in;
         low_ff    <= low_in;
      end
   end

   // the word reports status after this item's update
   assign status_next = status_in;

endmodule

`default_nettype wire

[hdl/eight_channel_hold_time_input_qualifier.sv]
// ----------------------------------------------------------------------------
// eight_channel_hold_time_input_qualifier
// Path: word accept into the input register, then into the result register;
//    the channel state updates as the word moves between the two.
// Throughput: one word per cycle while the result output is not stalled.
// Reset clears arm flags and counters, sets every status to high held,
//    hold_ticks to 10 and qualified_mask to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module eight_channel_hold_time_input_qualifier (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  [ehq_pkg::KIND_BITS-1:0]        req_kind,
   input  wire  [ehq_pkg::CHANNELS-1:0]         req_edge_mask,
   input  wire  [ehq_pkg::CHANNELS-1:0]         req_pin_levels,
   input  wire  [ehq_pkg::CHANNELS-1:0]         req_direct_levels,
   input  wire  [ehq_pkg::CHANNELS-1:0]         req_request_mask,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [ehq_pkg::WORD_BITS-1:0]        rsp_status_word,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [ehq_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire  [ehq_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import ehq_pkg::*;

   hold_type              hold_ff;
   logic [CHANNELS-1:0]   qual_ff;

   logic                  s1_valid_ff, s1_valid_in;
   kind_type              kind_ff;
   logic [CHANNELS-1:0]   edge_ff, pin_ff, direct_ff, request_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0]  word_ff, word_in;

   logic                  advance, req_take;
   chan_ctl_type          ctl;
   status_type            status_next [CHANNELS];

   // config registers; a zero hold time acts as one
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= HOLD_RESET;
         qual_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_HOLD_TICKS: begin
               hold_ff <= (HOLD_BITS'(csr_wdata) == '0) ? HOLD_MIN : HOLD_BITS'(csr_wdata);
            end
            REG_QUALIFIED_MASK: begin
               qual_ff <= csr_wdata[CHANNELS-1:0];
            end
            default: begin
               hold_ff <= hold_ff;
            end
         endcase
      end
   end

   assign csr_ready = ~s1_valid_ff;

   // handshake
   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = s1_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff    <= req_kind;
         edge_ff    <= req_edge_mask;
         pin_ff     <= req_pin_levels;
         direct_ff  <= req_direct_levels;
         request_ff <= req_request_mask;
      end
   end

   assign ctl.update = s1_valid_ff & advance;
   assign ctl.kind   = kind_ff;
   assign ctl.hold   = hold_ff;

   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      ehq_chan u_chan (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .edge_bit    (edge_ff[c]),
         .level       (pin_ff[c]),
         .status_next (status_next[c])
      );
   end

   // pack the status word
   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         if (!request_ff[c]) begin
            word_in[c*FIELD_BITS +: FIELD_BITS] = ST_NONE;
         end else if (qual_ff[c]) begin
            word_in[c*FIELD_BITS +: FIELD_BITS] = status_next[c];
         end else begin
            word_in[c*FIELD_BITS +: FIELD_BITS] = direct_ff[c] ? ST_HIGH : ST_LOW;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && advance) begin
         word_ff <= word_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status_word = word_ff;

`ifndef NO_ASSERTIONS
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff))
      else $error("input stalled without a held word and a waiting result");

   a_move_gives_result: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance) |=> rsp_valid_ff)
      else $error("word left the input register without a result");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      (!s1_valid_ff && rsp_valid_ff && !rsp_stall) |=> !rsp_valid_ff)
      else $error("result repeated after it was taken");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |-> !s1_valid_ff)
      else $error("config written while a word is in flight");
`endif

endmodule

`default_nettype wire

[tb/ehq_status_checker.sv]
// ----------------------------------------------------------------------------
// ehq_status_checker
// Watches the word, result and register channels of the hold-time input
// qualifier, keeps its own copy of the per-channel arm flags, counters and
// status, predicts the status word for every accepted word and compares it
// with the returned words in order.
// ----------------------------------------------------------------------------
module ehq_status_checker
   import ehq_pkg::*;
(
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   input  wire                       req_stall,
   input  wire  [KIND_BITS-1:0]      req_kind,
   input  wire  [CHANNELS-1:0]       req_edge_mask,
   input  wire  [CHANNELS-1:0]       req_pin_levels,
   input  wire  [CHANNELS-1:0]       req_direct_levels,
   input  wire  [CHANNELS-1:0]       req_request_mask,
   input  wire                       rsp_valid,
   input  wire                       rsp_stall,
   input  wire  [WORD_BITS-1:0]      rsp_status_word,
   input  wire                       csr_valid,
   input  wire                       csr_ready,
   input  wire  [CSR_IDX_BITS-1:0]   csr_index,
   input  wire  [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        fail_count,
   output int                        words_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SHOWN_LIMIT = 20;

   hold_type              hold_cfg;
   logic [CHANNELS-1:0]   qual_cfg;
   logic                  chan_armed [CHANNELS];
   status_type            chan_state [CHANNELS];
   count_type             hi_ticks   [CHANNELS];
   count_type             lo_ticks   [CHANNELS];

   logic [WORD_BITS-1:0]  expected_words [$];
   int                    errors = 0;

   initial begin
      fail_count = 0;
      words_pending = 0;
   end

   // advance the channel state for one word and pack the status word
   function automatic logic [WORD_BITS-1:0] qualify_and_pack(
      input kind_type            kind,
      input logic [CHANNELS-1:0] edges,
      input logic [CHANNELS-1:0] pins,
      input logic [CHANNELS-1:0] direct,
      input logic [CHANNELS-1:0] req
   );
      logic [WORD_BITS-1:0] word;
      hold_type             need;
      word = '0;
      // a zero hold time behaves as one tick
      need = (hold_cfg == '0) ? HOLD_MIN : hold_cfg;
      for (int c = 0; c < CHANNELS; c++) begin
         if (kind == KIND_EDGE) begin
            if (edges[c]) begin
               chan_armed[c] = 1'b1;
               hi_ticks[c] = '0;
               lo_ticks[c] = '0;
            end
         end else if (kind == KIND_TICK && chan_armed[c]) begin
            if (pins[c]) begin
               hi_ticks[c] = hi_ticks[c] + 1'b1;
               if (hi_ticks[c] >= need) begin
                  chan_state[c] = ST_HIGH;
                  hi_ticks[c] = '0;
               end
            end else begin
               lo_ticks[c] = lo_ticks[c] + 1'b1;
               if (lo_ticks[c] >= need) begin
                  chan_state[c] = ST_LOW;
                  lo_ticks[c] = '0;
               end
            end
         end
      end
      for (int c = 0; c < CHANNELS; c++) begin
         if (req[c]) begin
            if (qual_cfg[c])
               word[FIELD_BITS*c +: FIELD_BITS] = chan_state[c];
            else
               word[FIELD_BITS*c +: FIELD_BITS] = direct[c] ? ST_HIGH : ST_LOW;
         end
      end
      return word;
   endfunction

   always @(posedge clock) begin
      logic [WORD_BITS-1:0] want;
      if (reset) begin
         hold_cfg = HOLD_RESET;
         qual_cfg = '0;
         for (int c = 0; c < CHANNELS; c++) begin
            chan_armed[c] = 1'b0;
            chan_state[c] = ST_HIGH;
            hi_ticks[c] = '0;
            lo_ticks[c] = '0;
         end
         expected_words.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_HOLD_TICKS:     hold_cfg = csr_wdata[HOLD_BITS-1:0];
               REG_QUALIFIED_MASK: qual_cfg = csr_wdata[CHANNELS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               errors++;
               if (errors <= SHOWN_LIMIT)
                  $display("%0t: unexpected status word, expected none, actual %h",
                           $time, rsp_status_word);
            end else begin
               want = expected_words.pop_front();
               if (rsp_status_word !== want) begin
                  errors++;
                  if (errors <= SHOWN_LIMIT)
                     $display("%0t: status_word mismatch, expected %h, actual %h",
                              $time, want, rsp_status_word);
               end
            end
         end
         if (req_valid && !req_stall)
            expected_words.push_back(qualify_and_pack(req_kind, req_edge_mask,
               req_pin_levels, req_direct_levels, req_request_mask));
      end
      fail_count <= errors;
      words_pending <= expected_words.size();
   end

endmodule

[tb/eight_channel_hold_time_input_qualifier_test.sv]
// ----------------------------------------------------------------------------
// eight_channel_hold_time_input_qualifier_test
// Drives edge, tick and query words into the hold-time input qualifier under
// several register settings and idle/stall mixes; a separate checker predicts
// and compares every status word, this module only makes stimulus and
// reports the verdict.
// ----------------------------------------------------------------------------
module eight_channel_hold_time_input_qualifier_test;
   import ehq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int       CYCLE_LIMIT    = 400000;
   localparam int       PHASES         = 8;
   localparam int       PHASE_WORDS    = 215;
   localparam int       SETTLE_CYCLES  = 4;
   localparam kind_type KIND_SPARE     = 2'd3;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [KIND_BITS-1:0]       req_kind = KIND_QUERY;
   logic [CHANNELS-1:0]        req_edge_mask = '0;
   logic [CHANNELS-1:0]        req_pin_levels = '0;
   logic [CHANNELS-1:0]        req_direct_levels = '0;
   logic [CHANNELS-1:0]        req_request_mask = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [WORD_BITS-1:0]       rsp_status_word;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_BITS-1:0]    csr_index = REG_HOLD_TICKS;
   logic [CSR_DATA_BITS-1:0]   csr_wdata = '0;

   int fail_count;
   int words_pending;
   int idle_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;

   eight_channel_hold_time_input_qualifier dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_edge_mask     (req_edge_mask),
      .req_pin_levels    (req_pin_levels),
      .req_direct_levels (req_direct_levels),
      .req_request_mask  (req_request_mask),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status_word   (rsp_status_word),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   ehq_status_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_edge_mask     (req_edge_mask),
      .req_pin_levels    (req_pin_levels),
      .req_direct_levels (req_direct_levels),
      .req_request_mask  (req_request_mask),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status_word   (rsp_status_word),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .words_pending     (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_word(
      input kind_type            kind,
      input logic [CHANNELS-1:0] edges,
      input logic [CHANNELS-1:0] pins,
      input logic [CHANNELS-1:0] direct,
      input logic [CHANNELS-1:0] req
   );
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_edge_mask <= edges;
      req_pin_levels <= pins;
      req_direct_levels <= direct;
      req_request_mask <= req;
      do @(posedge clock); while (req_stall);
   endtask

   // stop sending and wait for every outstanding status word
   task automatic drain_words;
      req_valid <= 1'b0;
      do @(posedge clock); while (words_pending != 0);
   endtask

   task automatic apply_setting(input hold_type hold, input logic [CHANNELS-1:0] mask);
      drain_words();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= REG_HOLD_TICKS;
      csr_wdata <= hold;
      do @(posedge clock); while (!csr_ready);
      csr_index <= REG_QUALIFIED_MASK;
      csr_wdata <= {8'($urandom_range(255)), mask};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [CHANNELS-1:0] pin_now;
      logic [CHANNELS-1:0] flip;
      logic [CHANNELS-1:0] req;
      logic [CHANNELS-1:0] pins;
      hold_type            hold;
      logic [CHANNELS-1:0] mask;
      int                  r;
      pin_now = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: every channel reports its direct level
      send_word(KIND_QUERY, 8'h00, 8'h00, 8'h00, 8'hFF);
      send_word(KIND_QUERY, 8'h00, 8'h00, 8'hFF, 8'hFF);
      send_word(KIND_QUERY, 8'hFF, 8'hFF, 8'hAA, 8'h00);
      send_word(KIND_SPARE, 8'hFF, 8'h00, 8'h5A, 8'hFF);
      send_word(KIND_EDGE, 8'hFF, 8'h00, 8'h0F, 8'hFF);

      // shortest hold time, all channels qualified
      apply_setting(HOLD_MIN, 8'hFF);
      send_word(KIND_QUERY, 8'h00, 8'h00, 8'h00, 8'hFF);
      send_word(KIND_TICK, 8'h00, 8'h00, 8'h00, 8'hFF);
      send_word(KIND_TICK, 8'h00, 8'hFF, 8'h00, 8'hFF);
      send_word(KIND_EDGE, 8'h0F, 8'h00, 8'hFF, 8'hFF);
      send_word(KIND_TICK, 8'hFF, 8'h55, 8'h00, 8'hFF);
      send_word(KIND_EDGE, 8'h00, 8'hAA, 8'h00, 8'hFF);
      send_word(KIND_SPARE, 8'hFF, 8'h00, 8'hFF, 8'hFF);
      send_word(KIND_TICK, 8'h00, 8'h00, 8'hFF, 8'hF0);

      // two-tick hold, half the channels qualified
      apply_setting(16'd2, 8'h0F);
      send_word(KIND_TICK, 8'h00, 8'hFF, 8'h00, 8'hFF);
      send_word(KIND_TICK, 8'h00, 8'hFF, 8'h55, 8'hFF);
      send_word(KIND_EDGE, 8'hF0, 8'h00, 8'hAA, 8'hFF);
      send_word(KIND_TICK, 8'h00, 8'h00, 8'h00, 8'hFF);
      send_word(KIND_TICK, 8'h00, 8'h00, 8'hFF, 8'hFF);
      send_word(KIND_QUERY, 8'h00, 8'h00, 8'h0F, 8'h3C);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin hold = HOLD_MIN;  mask = 8'hFF; end
            1: begin hold = 16'd4;     mask = 8'hA5; end
            2: begin hold = 16'd2;     mask = 8'hFF; end
            3: begin hold = 16'hFFFF;  mask = 8'hFF; end
            4: begin hold = 16'd7;     mask = 8'h00; end
            5: begin hold = 16'd3;     mask = 8'h5A; end
            6: begin hold = HOLD_MIN;  mask = 8'h3C; end
            default: begin hold = 16'd5; mask = 8'hFF; end
         endcase
         apply_setting(hold, mask);
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 87; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 87; end
            default: begin idle_pct = 18; stall_pct = 18; end
         endcase
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n == PHASE_WORDS / 2)
               drain_words();
            r = $urandom_range(99);
            req = ($urandom_range(9) < 7) ? 8'hFF : 8'($urandom_range(255));
            if (r < 12) begin
               // pins change, edge word mostly names the changed channels
               flip = 8'($urandom_range(255)) & 8'($urandom_range(255));
               pin_now = pin_now ^ flip;
               if ($urandom_range(99) < 15)
                  flip = 8'($urandom_range(255));
               send_word(KIND_EDGE, flip, pin_now, 8'($urandom_range(255)), req);
            end else if (r < 75) begin
               // mostly steady pins so counters run up to the hold time
               pins = ($urandom_range(99) < 5) ? 8'($urandom_range(255)) : pin_now;
               send_word(KIND_TICK, 8'($urandom_range(255)), pins,
                         8'($urandom_range(255)), req);
            end else begin
               send_word((r < 88) ? KIND_QUERY : KIND_SPARE, 8'($urandom_range(255)),
                         8'($urandom_range(255)), 8'($urandom_range(255)), req);
            end
         end
      end

      drain_words();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
